[hdl/bacf_pkg.sv]
// Shared types and constants of the backbone atom clash filter.
package bacf_pkg;

	localparam int CoordW = 16;
	localparam int ClassW = 2;
	localparam int AtomW  = 3 * CoordW + ClassW;
	localparam int DistW  = 36;
	localparam int RadW   = 8;
	localparam int ScaleW = 9;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 36;

	localparam logic [CfgIdxW-1:0] REG_RADIUS_N  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RADIUS_CA = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_RADIUS_C  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SCALE_14  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SCALE_15  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_MAX_SPAN  = 3'd5;

	localparam logic [ClassW-1:0] CLS_N  = 2'd0;
	localparam logic [ClassW-1:0] CLS_CA = 2'd1;
	localparam logic [ClassW-1:0] CLS_C  = 2'd2;

	localparam logic [2:0] FAIL_OK    = 3'd0;
	localparam logic [2:0] FAIL_14    = 3'd1;
	localparam logic [2:0] FAIL_15    = 3'd2;
	localparam logic [2:0] FAIL_FAR   = 3'd3;
	localparam logic [2:0] FAIL_LONG  = 3'd4;

	// Test kinds carried with a pair through the datapath.
	localparam logic [1:0] TEST_14   = 2'd0;
	localparam logic [1:0] TEST_15   = 2'd1;
	localparam logic [1:0] TEST_FAR  = 2'd2;
	localparam logic [1:0] TEST_SPAN = 2'd3;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic [ClassW-1:0]        cls;
	} atom_t;

	typedef struct packed {
		logic       load;   // latch the new atom
		logic       issue;  // a store read was issued last cycle, test it
		logic [1:0] test;
	} dp_cmd_t;

	typedef struct packed {
		logic       hit;    // a test failed (valid with kind)
		logic [1:0] test;
		logic       busy;   // tests still in flight
	} dp_stat_t;

endpackage

[hdl/backbone_atom_clash_filter.sv]
// m_tvalid rises with no store reads at positions below 3; otherwise it follows the clash
// tests and, for slot 2 at positions from 13 with no clash failure, the span test.
// Throughput: one atom at a time; a new beat is taken only after the result beat is taken,
// and the store read port issues one earlier atom per cycle.
// Reset (arst_n low) sets control and config to defaults; the atom store has no reset.
// Top level of the backbone atom clash filter.
module backbone_atom_clash_filter
	import bacf_pkg::*;
#(
	parameter int MAX_ATOMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// atom_position[9:0], residue_slot[11:10], coord_x[27:12], coord_y[43:28],
	// coord_z[59:44], atom_class[61:60], zero fill
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], fail_kind[3:1], zero fill
	output logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_ATOMS);

	logic [RadW-1:0]   radius_n_q, radius_ca_q, radius_c_q;
	logic [ScaleW-1:0] scale_14_q, scale_15_q;
	logic [DistW-1:0]  max_span_q;
	atom_t             new_atom, old_atom;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [2:0]        fail;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_n_q  <= '0;
			radius_ca_q <= '0;
			radius_c_q  <= '0;
			scale_14_q  <= 9'd256;
			scale_15_q  <= 9'd256;
			max_span_q  <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RADIUS_N:  radius_n_q  <= cfg_data[RadW-1:0];
				REG_RADIUS_CA: radius_ca_q <= cfg_data[RadW-1:0];
				REG_RADIUS_C:  radius_c_q  <= cfg_data[RadW-1:0];
				REG_SCALE_14:  scale_14_q  <= cfg_data[ScaleW-1:0];
				REG_SCALE_15:  scale_15_q  <= cfg_data[ScaleW-1:0];
				REG_MAX_SPAN:  max_span_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign new_atom.x   = s_tdata[27:12];
	assign new_atom.y   = s_tdata[43:28];
	assign new_atom.z   = s_tdata[59:44];
	assign new_atom.cls = s_tdata[61:60];

	bacf_ram #(.Width(AtomW), .Depth(MAX_ATOMS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (new_atom),
		.raddr (raddr),
		.rdata (old_atom)
	);

	bacf_ctrl #(.MaxAtoms(MAX_ATOMS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pos    (s_tdata[9:0]),
		.in_slot   (s_tdata[11:10]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_fail  (fail),
		.we        (we),
		.waddr     (waddr),
		.raddr     (raddr),
		.cmd       (cmd),
		.stat      (stat)
	);

	bacf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.new_atom    (new_atom),
		.old_atom    (old_atom),
		.radius_n    (radius_n_q),
		.radius_ca   (radius_ca_q),
		.radius_c    (radius_c_q),
		.scale_14    (scale_14_q),
		.scale_15    (scale_15_q),
		.max_span_sq (max_span_q),
		.stat        (stat)
	);

	assign m_tdata = {4'd0, fail, fail == FAIL_OK};

endmodule

[hdl/bacf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bacf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/bacf_datapath.sv]
// Distance and threshold datapath: pipelined pair tests against the new atom.
module bacf_datapath
	import bacf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  atom_t             new_atom,
	input  atom_t             old_atom,
	input  logic [RadW-1:0]   radius_n,
	input  logic [RadW-1:0]   radius_ca,
	input  logic [RadW-1:0]   radius_c,
	input  logic [ScaleW-1:0] scale_14,
	input  logic [ScaleW-1:0] scale_15,
	input  logic [DistW-1:0]  max_span_sq,
	output dp_stat_t          stat
);

	function automatic logic [RadW-1:0] radius_of(input logic [ClassW-1:0] c,
			input logic [RadW-1:0] rn, input logic [RadW-1:0] rca,
			input logic [RadW-1:0] rc);
		case (c)
			CLS_N:   radius_of = rn;
			CLS_CA:  radius_of = rca;
			CLS_C:   radius_of = rc;
			default: radius_of = '0;
		endcase
	endfunction

	atom_t cur_q;

	// Stage 1: differences, radius sum, scale square.
	logic              v_s1;
	logic [1:0]        t_s1;
	logic signed [16:0] dx_s1, dy_s1, dz_s1;
	logic [RadW:0]     rs_s1;
	logic [17:0]       sc2_s1;
	// Stage 2: squares.
	logic              v_s2;
	logic [1:0]        t_s2;
	logic [33:0]       qx_s2, qy_s2, qz_s2;
	logic [17:0]       c2_s2;
	logic [17:0]       sc2_s2;
	// Stage 3: distance sum and scaled threshold.
	logic              v_s3;
	logic [1:0]        t_s3;
	logic [DistW-1:0]  d2_s3;
	logic [17:0]       c2_s3;
	logic [35:0]       thr_s3;
	// Stage 4: compare.
	logic              v_s4;
	logic              hit_s4;
	logic [1:0]        t_s4;

	logic [ScaleW-1:0] scale_sel;
	logic [51:0]       lhs;

	always_comb begin
		scale_sel = (cmd.test == TEST_14) ? scale_14 : scale_15;
		lhs = {d2_s3, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= new_atom;
		end
		t_s1   <= cmd.test;
		dx_s1  <= 17'(cur_q.x) - 17'(old_atom.x);
		dy_s1  <= 17'(cur_q.y) - 17'(old_atom.y);
		dz_s1  <= 17'(cur_q.z) - 17'(old_atom.z);
		rs_s1  <= {1'b0, radius_of(cur_q.cls, radius_n, radius_ca, radius_c)}
			+ {1'b0, radius_of(old_atom.cls, radius_n, radius_ca, radius_c)};
		sc2_s1 <= 18'(scale_sel) * 18'(scale_sel);

		t_s2   <= t_s1;
		qx_s2  <= 34'(dx_s1 * dx_s1);
		qy_s2  <= 34'(dy_s1 * dy_s1);
		qz_s2  <= 34'(dz_s1 * dz_s1);
		c2_s2  <= 18'(rs_s1) * 18'(rs_s1);
		sc2_s2 <= sc2_s1;

		t_s3   <= t_s2;
		d2_s3  <= 36'(qx_s2) + 36'(qy_s2) + 36'(qz_s2);
		c2_s3  <= c2_s2;
		thr_s3 <= c2_s2 * sc2_s2;

		t_s4 <= t_s3;
		case (t_s3)
			TEST_14, TEST_15: hit_s4 <= lhs < 52'(thr_s3);
			TEST_FAR:         hit_s4 <= d2_s3 < 36'(c2_s3);
			default:          hit_s4 <= d2_s3 > max_span_sq;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign stat.hit  = v_s4 & hit_s4;
	assign stat.test = t_s4;
	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

[hdl/bacf_ctrl.sv]
// Sequencer: walks store addresses for each atom and resolves the first failure.
module bacf_ctrl
	import bacf_pkg::*;
#(
	parameter int MaxAtoms = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [9:0]                  in_pos,
	input  logic [1:0]                  in_slot,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  out_fail,
	output logic                        we,
	output logic [$clog2(MaxAtoms)-1:0] waddr,
	output logic [$clog2(MaxAtoms)-1:0] raddr,
	output dp_cmd_t                     cmd,
	input  dp_stat_t                    stat
);

	localparam int AW = $clog2(MaxAtoms);
	localparam int PW = (AW > 10) ? AW : 10;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASH = 3'd1;
	localparam logic [2:0] ST_SPAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]    state_q;
	logic [PW-1:0] pos_q;
	logic [PW:0]   k_q;       // next address to issue (signed headroom)
	logic [1:0]    test_q;
	logic          issue_q;
	logic          span_q;    // a span pass is pending after clash tests
	logic [2:0]    fail_q;
	logic          stored;
	logic [PW-1:0] pos_in;

	assign pos_in  = PW'(in_pos);
	assign stored  = {1'b0, pos_in} < (PW+1)'(MaxAtoms);
	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign we      = in_valid && in_ready && stored;
	assign waddr   = pos_in[AW-1:0];
	assign raddr   = k_q[AW-1:0];
	assign cmd.load  = we;
	assign cmd.issue = issue_q;
	assign cmd.test  = test_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			k_q       <= '0;
			test_q    <= TEST_14;
			issue_q   <= 1'b0;
			span_q    <= 1'b0;
			fail_q    <= FAIL_OK;
			out_valid <= 1'b0;
			out_fail  <= FAIL_OK;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			issue_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						pos_q   <= pos_in;
						fail_q  <= FAIL_OK;
						if (stored && pos_in >= PW'(3)) begin
							k_q    <= (PW+1)'(pos_in) - (PW+1)'(3);
							test_q <= TEST_14;
							span_q <= (in_slot == 2'd2) && pos_in >= PW'(13);
							state_q <= ST_CLASH;
						end else begin
							out_valid <= 1'b1;
							out_fail  <= FAIL_OK;
						end
					end
				end
				ST_CLASH: begin
					// Issue from pos-3 down to 0; the kind follows the address.
					issue_q <= 1'b1;
					test_q  <= (k_q == (PW+1)'(pos_q) - (PW+1)'(3)) ? TEST_14 :
						(k_q == (PW+1)'(pos_q) - (PW+1)'(4)) ? TEST_15 : TEST_FAR;
					if (k_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q - (PW+1)'(1);
					end
				end
				ST_SPAN: begin
					issue_q <= 1'b1;
					test_q  <= TEST_SPAN;
					if (k_q < (PW+1)'(4)) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q - (PW+1)'(3);
					end
				end
				ST_DRAIN: begin
					if (!stat.busy && !issue_q) begin
						if (fail_q == FAIL_OK && span_q) begin
							span_q  <= 1'b0;
							k_q     <= (PW+1)'(pos_q) - (PW+1)'(12);
							state_q <= ST_SPAN;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_fail  <= fail_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// First failing test in issue order wins.
			if (stat.hit && fail_q == FAIL_OK) begin
				case (stat.test)
					TEST_14:  fail_q <= FAIL_14;
					TEST_15:  fail_q <= FAIL_15;
					TEST_FAR: fail_q <= FAIL_FAR;
					default:  fail_q <= FAIL_LONG;
				endcase
			end
		end
	end

endmodule

[dv/tb_backbone_atom_clash_filter.sv]
// Self-checking testbench of the backbone atom clash filter with its own clash predictor.
`timescale 1ns / 1ps

module tb_backbone_atom_clash_filter;
	import bacf_pkg::*;

	localparam int Depth    = 1024;
	localparam int FillTop  = 530;

	typedef struct packed {
		logic       accepted;
		logic [2:0] fail_kind;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	atom_t chain_atoms [Depth];
	logic [RadW-1:0] rad_n, rad_ca, rad_c;
	logic [ScaleW-1:0] scale14, scale15;
	logic [DistW-1:0] span_limit;
	verdict_t verdict_q[$];
	int written_top;
	int fails;
	int results_seen;
	int kind_count [5];
	bit steady;
	int wx, wy, wz;

	backbone_atom_clash_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_backbone_atom_clash_filter NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint unsigned dist_sq(atom_t a, atom_t b);
		longint dx, dy, dz;
		dx = longint'($signed(a.x)) - longint'($signed(b.x));
		dy = longint'($signed(a.y)) - longint'($signed(b.y));
		dz = longint'($signed(a.z)) - longint'($signed(b.z));
		return longint'(dx * dx + dy * dy + dz * dz);
	endfunction

	function automatic longint unsigned radius_of(logic [ClassW-1:0] cls);
		case (cls)
			CLS_N:   return rad_n;
			CLS_CA:  return rad_ca;
			CLS_C:   return rad_c;
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned contact_sq(atom_t a, atom_t b);
		longint unsigned s;
		s = radius_of(a.cls) + radius_of(b.cls);
		return s * s;
	endfunction

	function automatic bit scaled_clash(atom_t a, atom_t b, logic [ScaleW-1:0] sc);
		longint unsigned s;
		s = sc;
		return (dist_sq(a, b) << 16) < contact_sq(a, b) * (s * s);
	endfunction

	// Stores the atom and returns the first failing check, as the block does.
	function automatic logic [2:0] judge_atom(int pos, logic [1:0] slot, atom_t a);
		logic [2:0] kind;
		int k;
		kind = FAIL_OK;
		chain_atoms[pos] = a;
		if (pos >= 3) begin
			if (scaled_clash(a, chain_atoms[pos-3], scale14)) begin
				kind = FAIL_14;
			end else if (pos >= 4 && scaled_clash(a, chain_atoms[pos-4], scale15)) begin
				kind = FAIL_15;
			end else begin
				for (k = pos - 5; k >= 0; k--) begin
					if (dist_sq(a, chain_atoms[k]) < contact_sq(a, chain_atoms[k])) begin
						kind = FAIL_FAR;
						break;
					end
				end
			end
			if (kind == FAIL_OK && slot == 2'd2 && pos >= 13) begin
				k = pos - 12;
				while (k >= 1) begin
					if (dist_sq(a, chain_atoms[k]) > span_limit) begin
						kind = FAIL_LONG;
						break;
					end
					if (k < 4) break;
					k -= 3;
				end
			end
		end
		return kind;
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, longint unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CfgDataW-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIUS_N:  rad_n = value[RadW-1:0];
			REG_RADIUS_CA: rad_ca = value[RadW-1:0];
			REG_RADIUS_C:  rad_c = value[RadW-1:0];
			REG_SCALE_14:  scale14 = value[ScaleW-1:0];
			REG_SCALE_15:  scale15 = value[ScaleW-1:0];
			REG_MAX_SPAN:  span_limit = value[DistW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_all(int rn, int rca, int rc, int s14, int s15, longint unsigned span);
		write_reg(REG_RADIUS_N, rn);
		write_reg(REG_RADIUS_CA, rca);
		write_reg(REG_RADIUS_C, rc);
		write_reg(REG_SCALE_14, s14);
		write_reg(REG_SCALE_15, s15);
		write_reg(REG_MAX_SPAN, span);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_atom(int pos, logic [1:0] slot, int x, int y, int z,
			logic [ClassW-1:0] cls);
		int gap;
		atom_t a;
		verdict_t v;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a.x = x[15:0];
		a.y = y[15:0];
		a.z = z[15:0];
		a.cls = cls;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, cls, a.z, a.y, a.x, slot, pos[9:0]};
		do @(posedge clk); while (!s_tready);
		v.fail_kind = judge_atom(pos, slot, a);
		v.accepted = (v.fail_kind == FAIL_OK);
		verdict_q.push_back(v);
		if (pos + 1 > written_top) written_top = pos + 1;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic int walk(int c);
		c += $signed($urandom_range(0, 240)) - 120;
		if (c > 30000) c = 30000;
		if (c < -30000) c = -30000;
		return c;
	endfunction

	// Random class with the unused class code now and then.
	function automatic logic [ClassW-1:0] rand_cls();
		return ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			verdict_t v;
			if (verdict_q.size() == 0) begin
				$error("result beat with no expectation waiting: %h", m_tdata);
				fails++;
			end else begin
				v = verdict_q.pop_front();
				results_seen++;
				if (m_tdata[0] !== v.accepted) begin
					$error("accepted: expected %0d, actual %0d", v.accepted, m_tdata[0]);
					fails++;
				end
				if (m_tdata[3:1] !== v.fail_kind) begin
					$error("fail_kind: expected %0d, actual %0d", v.fail_kind, m_tdata[3:1]);
					fails++;
				end
				if (v.fail_kind <= FAIL_LONG) kind_count[v.fail_kind]++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= (pick_gap() == 0);
		end
	end

	task automatic test_directed();
		int i;
		set_all(64, 64, 64, 256, 256, 64'd4000000);
		send_atom(0, 2'd3, -32768, 32767, -32768, 2'd3);
		send_atom(1, 2'd2, 32767, -32768, 32767, CLS_C);
		send_atom(2, 2'd1, 0, 0, 0, CLS_CA);
		for (i = 0; i <= 14; i++) begin
			send_atom(i, (i == 14) ? 2'd2 : 2'd0, i * 200, 0, 0, (i == 7) ? 2'd3 : 2'(i % 3));
			if (i == 3) begin
				send_atom(3, 2'd0, 10, 0, 0, CLS_N);
				send_atom(3, 2'd0, 600, 0, 0, CLS_N);
			end
			if (i == 4) begin
				send_atom(4, 2'd0, 10, 0, 0, CLS_CA);
				send_atom(4, 2'd0, 800, 0, 0, CLS_CA);
			end
			if (i == 5) begin
				send_atom(5, 2'd0, 10, 0, 0, CLS_C);
				send_atom(5, 2'd0, 1000, 0, 0, CLS_C);
			end
		end
		drain();
	endtask

	task automatic test_chain_fill();
		int p;
		set_all($urandom_range(30, 60), $urandom_range(30, 60), $urandom_range(30, 60),
			$urandom_range(200, 256), $urandom_range(200, 256), 64'd300000000);
		wx = 0; wy = 0; wz = 0;
		for (p = 0; p < FillTop; p++) begin
			steady = (p % 100) < 15;
			wx = walk(wx); wy = walk(wy); wz = walk(wz);
			send_atom(p, 2'($urandom_range(0, 3)), wx, wy, wz, rand_cls());
		end
		steady = 0;
		drain();
	endtask

	// Revisits written positions, mostly near the previous atom, partly anywhere.
	task automatic test_revisit(int n);
		int i, p;
		atom_t b;
		for (i = 0; i < n; i++) begin
			p = $urandom_range(0, written_top - 1);
			if (p > 0 && $urandom_range(0, 3) != 0) begin
				b = chain_atoms[p-1];
				send_atom(p, 2'($urandom_range(0, 3)), walk($signed(b.x)), walk($signed(b.y)),
					walk($signed(b.z)), rand_cls());
			end else begin
				send_atom(p, 2'($urandom_range(0, 3)), $signed($urandom_range(0, 65535)) - 32768,
					$signed($urandom_range(0, 65535)) - 32768,
					$signed($urandom_range(0, 65535)) - 32768, rand_cls());
			end
		end
		drain();
	endtask

	task automatic test_extreme_settings();
		set_all(255, 255, 255, 0, 0, 64'd0);
		test_revisit(10);
		set_all(0, 0, 0, 256, 256, 64'hF_FFFF_FFFF);
		test_revisit(10);
		set_all(255, 0, 128, 256, 0, 64'd50000000);
		test_revisit(10);
		set_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 256), $urandom_range(0, 256), 64'd2000000);
		test_revisit(10);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 0;
		fails = 0;
		results_seen = 0;
		written_top = 0;
		for (int i = 0; i < 5; i++) kind_count[i] = 0;
		rad_n = 0; rad_ca = 0; rad_c = 0;
		scale14 = 256; scale15 = 256;
		span_limit = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_chain_fill();
		test_extreme_settings();
		$display("Checked %0d results over a chain of %0d atoms under six register settings.",
			results_seen, written_top);
		$display("Verdicts ok/1-4/1-5/far/long: %0d/%0d/%0d/%0d/%0d", kind_count[0],
			kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
		if (fails == 0) begin
			$display("tb_backbone_atom_clash_filter OK");
		end else begin
			$display("tb_backbone_atom_clash_filter NOT OK");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/bacf_pkg.sv
hdl/bacf_ram.sv
hdl/bacf_datapath.sv
hdl/bacf_ctrl.sv
hdl/backbone_atom_clash_filter.sv
dv/tb_backbone_atom_clash_filter.sv
